// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Each check uses clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- sv/dpt_pkg.sv -----
// ----------------------------------------------------------------------------
// dpt_pkg
// Types and state codes for the directive pair tokenizer.
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int PosW   = 12;
  localparam int CountW = 4;

  localparam logic [3:0] ST_BEFORE_KEY  = 4'd0;
  localparam logic [3:0] ST_KEY         = 4'd1;
  localparam logic [3:0] ST_BEFORE_NAME = 4'd2;
  localparam logic [3:0] ST_NAME        = 4'd3;
  localparam logic [3:0] ST_BEFORE_EQ   = 4'd4;
  localparam logic [3:0] ST_EQ          = 4'd5;
  localparam logic [3:0] ST_QUOTE       = 4'd6;
  localparam logic [3:0] ST_VALUE       = 4'd7;
  localparam logic [3:0] ST_ENDQUOTE    = 4'd8;
  localparam logic [3:0] ST_UNKNOWN     = 4'd9;

  localparam logic [7:0] QUOTE_CH = 8'd34;
  localparam logic [7:0] EQUAL_CH = 8'd61;

  typedef struct packed {
    logic [3:0]        tok_state;
    logic [CountW-1:0] pairs_done;
    logic [PosW-1:0]   char_pos;
    logic              line_stopped;
  } dpt_state_t;

  typedef struct packed {
    logic [PosW-1:0]   position;
    logic              key_begin;
    logic              key_end;
    logic              name_begin;
    logic              name_end;
    logic              value_begin;
    logic              value_close;
    logic              value_extend;
    logic [CountW-1:0] pair_index;
    logic [CountW-1:0] pair_count;
    logic              ignored;
  } dpt_result_t;

endpackage

// ----- sv/dpt_step.sv -----
// ----------------------------------------------------------------------------
// dpt_step
// Per-character tokenizer update: next state and the result marks.
// ----------------------------------------------------------------------------
module dpt_step #(
  parameter int MAX_PAIRS = 10,
  parameter int MAX_LINE  = 4096
) (
  input  dpt_pkg::dpt_state_t  cur,
  input  logic [7:0]           ch,
  input  logic                 line_start,
  output dpt_pkg::dpt_state_t  nxt,
  output dpt_pkg::dpt_result_t res
);
  import dpt_pkg::*;

  localparam int PosLimitInt = (MAX_LINE - 1 < 4095) ? MAX_LINE - 1 : 4095;
  localparam logic [PosW-1:0]   POS_LIMIT = PosW'(PosLimitInt);
  localparam logic [CountW-1:0] PAIR_LIM  = CountW'(MAX_PAIRS);

  dpt_state_t s;
  logic       q;
  logic       ws;
  logic       can_extend;
  logic       stop;

  always_comb begin
    // clear state ahead of the first character of a line
    s = line_start ? '0 : cur;
    s.tok_state = line_start ? ST_BEFORE_KEY : cur.tok_state;

    q          = (ch == QUOTE_CH);
    ws         = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
    can_extend = (s.pairs_done != '0) && q;
    stop       = s.line_stopped || (ch == 8'd0) || (s.pairs_done >= PAIR_LIM);

    nxt = s;
    res = '0;
    res.position = s.char_pos;
    if (s.char_pos < POS_LIMIT) begin
      nxt.char_pos = s.char_pos + PosW'(1);
    end

    if (stop) begin
      if (ch == 8'd0) begin
        nxt.line_stopped = 1'b1;
      end
      res.ignored = 1'b1;
    end else begin
      unique case (s.tok_state)
        ST_BEFORE_KEY: begin
          if (!ws) begin
            res.key_begin = 1'b1;
            nxt.tok_state = ST_KEY;
          end
        end
        ST_KEY: begin
          if (ws) begin
            res.key_end   = 1'b1;
            nxt.tok_state = ST_BEFORE_NAME;
          end
        end
        ST_BEFORE_NAME: begin
          if (can_extend) begin
            res.value_extend = 1'b1;
            res.pair_index   = s.pairs_done - CountW'(1);
            nxt.tok_state    = ST_ENDQUOTE;
          end else if (!ws) begin
            res.name_begin = 1'b1;
            res.pair_index = s.pairs_done;
            nxt.tok_state  = ST_NAME;
          end
        end
        ST_NAME: begin
          if (can_extend) begin
            res.value_extend = 1'b1;
            res.pair_index   = s.pairs_done - CountW'(1);
            nxt.tok_state    = ST_ENDQUOTE;
          end else if (ws) begin
            res.name_end   = 1'b1;
            res.pair_index = s.pairs_done;
            nxt.tok_state  = ST_BEFORE_EQ;
          end else if (ch == EQUAL_CH) begin
            res.name_end   = 1'b1;
            res.pair_index = s.pairs_done;
            nxt.tok_state  = ST_EQ;
          end
        end
        ST_BEFORE_EQ: begin
          if (can_extend) begin
            res.value_extend = 1'b1;
            res.pair_index   = s.pairs_done - CountW'(1);
            nxt.tok_state    = ST_ENDQUOTE;
          end else if (ch == EQUAL_CH) begin
            nxt.tok_state = ST_EQ;
          end else if (!ws) begin
            nxt.tok_state = ST_UNKNOWN;
          end
        end
        ST_EQ: begin
          if (q) begin
            nxt.tok_state = ST_QUOTE;
          end else if (!ws) begin
            nxt.tok_state = ST_UNKNOWN;
          end
        end
        ST_QUOTE: begin
          res.value_begin = 1'b1;
          res.pair_index  = s.pairs_done;
          if (q) begin
            res.value_close = 1'b1;
            nxt.pairs_done  = s.pairs_done + CountW'(1);
            nxt.tok_state   = ST_ENDQUOTE;
          end else begin
            nxt.tok_state = ST_VALUE;
          end
        end
        ST_VALUE: begin
          if (q) begin
            res.value_close = 1'b1;
            res.pair_index  = s.pairs_done;
            nxt.pairs_done  = s.pairs_done + CountW'(1);
            nxt.tok_state   = ST_ENDQUOTE;
          end
        end
        ST_ENDQUOTE: begin
          if (can_extend) begin
            res.value_extend = 1'b1;
            res.pair_index   = s.pairs_done - CountW'(1);
            nxt.tok_state    = ST_ENDQUOTE;
          end else if (ws) begin
            nxt.tok_state = ST_BEFORE_NAME;
          end else begin
            nxt.tok_state = ST_UNKNOWN;
          end
        end
        default: begin
          if (can_extend) begin
            res.value_extend = 1'b1;
            res.pair_index   = s.pairs_done - CountW'(1);
            nxt.tok_state    = ST_ENDQUOTE;
          end else begin
            nxt.tok_state = ST_UNKNOWN;
          end
        end
      endcase
    end

    res.pair_count = nxt.pairs_done;
  end

endmodule

// ----- sv/directive_pair_tokenizer.sv -----
// ----------------------------------------------------------------------------
// directive_pair_tokenizer
// Marks keyword and name="value" pair boundaries in a directive line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one line character per
//   transfer in in_ch; in_line_start marks the first character of a line
//   and clears the tokenizer before that character is handled.
//   Result channel (out_valid/out_ready) returns exactly one result per
//   input transfer, in order: the character position, the boundary marks,
//   the pair index the marks refer to, the completed pair count and the
//   ignored flag (line ended by a zero byte or pair limit reached).
//   The result is registered: out_valid rises in the cycle after the input transfer.
//   Throughput: one character per cycle while out_ready holds; the tokenizer
//   state update is one small combinational step ahead of the result register.
//   The result register doubles as the stall buffer: in_ready is high
//   whenever it is empty or being drained in the same cycle, so a stalled
//   receiver back-pressures the sender after one held result.
//   Reset (rst_n low, synchronous) empties the result register and returns
//   the tokenizer to "before keyword" with zero pairs and position zero.
// ----------------------------------------------------------------------------
module directive_pair_tokenizer #(
  parameter int MAX_PAIRS = 10,
  parameter int MAX_LINE  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_line_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_position,
  output logic        out_key_begin,
  output logic        out_key_end,
  output logic        out_name_begin,
  output logic        out_name_end,
  output logic        out_value_begin,
  output logic        out_value_close,
  output logic        out_value_extend,
  output logic [3:0]  out_pair_index,
  output logic [3:0]  out_pair_count,
  output logic        out_ignored
);
  import dpt_pkg::*;

  `include "assert_macros.svh"

  dpt_state_t  state_r;
  dpt_state_t  state_nxt;
  dpt_result_t result_r;
  dpt_result_t result_nxt;
  logic        out_valid_r;
  logic        in_xfer;
  logic [5:0]  mark_kinds;

  // accept while the result register is empty or draining this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  dpt_step #(
    .MAX_PAIRS (MAX_PAIRS),
    .MAX_LINE  (MAX_LINE)
  ) u_step (
    .cur        (state_r),
    .ch         (in_ch),
    .line_start (in_line_start),
    .nxt        (state_nxt),
    .res        (result_nxt)
  );

  // tokenizer state: advance only on an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{tok_state: ST_BEFORE_KEY, pairs_done: '0, char_pos: '0,
                   line_stopped: 1'b0};
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // result valid flag: set on transfer in, drop when taken with nothing new
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload: hold while stalled, load on each input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = result_r.position;
  assign out_key_begin    = result_r.key_begin;
  assign out_key_end      = result_r.key_end;
  assign out_name_begin   = result_r.name_begin;
  assign out_name_end     = result_r.name_end;
  assign out_value_begin  = result_r.value_begin;
  assign out_value_close  = result_r.value_close;
  assign out_value_extend = result_r.value_extend;
  assign out_pair_index   = result_r.pair_index;
  assign out_pair_count   = result_r.pair_count;
  assign out_ignored      = result_r.ignored;

  // kinds of mark on the held result; an empty value counts as one kind
  assign mark_kinds = {result_r.key_begin, result_r.key_end, result_r.name_begin,
                       result_r.name_end, result_r.value_begin || result_r.value_close,
                       result_r.value_extend};

  // an ignored character carries no marks
  `AST_IMPL(a_ignored_no_marks, out_valid_r && result_r.ignored, mark_kinds == '0)

  // the pair count never passes the limit
  `AST_IMPL(a_count_limit, out_valid_r, result_r.pair_count <= 4'(MAX_PAIRS))

  // a line start always reports position zero
  `AST_NEXT(a_line_start_pos, in_xfer && in_line_start, result_r.position == '0)

  // at most one kind of mark per character, apart from an empty value
  `AST_IMPL(a_marks_exclusive, out_valid_r, $onehot0(mark_kinds))

endmodule

// ----- tb/sv/tb_directive_pair_tokenizer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_directive_pair_tokenizer
// Self-checking bench for the directive pair tokenizer.
//
// Streams directive lines through the input channel and predicts every result
// with a cycle-free model of the tokenizer held in this module. A short
// hand-written line walks most tokenizer transitions. Random lines follow:
// mostly well-formed keyword plus name="value" lines with random content, some
// corrupted, some raw byte noise, and one long line of a few hundred
// characters. Sender gaps and receiver stalls change by
// phase, and a long receiver hold-off fills the block so that it stalls its
// input.
// ----------------------------------------------------------------------------
module tb_directive_pair_tokenizer;
  import dpt_pkg::*;

  localparam int PAIR_LIMIT   = 10;
  localparam int LINE_LIMIT   = 4096;
  localparam int POS_LIMIT    = (LINE_LIMIT - 1) < 4095 ? (LINE_LIMIT - 1) : 4095;
  localparam int RANDOM_CHARS = 1350;
  localparam int LONG_LINE    = 300;
  localparam int PHASE_LEN    = 150;
  localparam int HOLD_CYCLES  = 64;
  localparam int HOLD_EVERY   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS   = 5_000_000;

  localparam logic [7:0] NUL_CH   = 8'd0;
  localparam logic [7:0] TAB_CH   = 8'd9;
  localparam logic [7:0] CR_CH    = 8'd13;
  localparam logic [7:0] SPACE_CH = 8'd32;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_start;
  } line_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ch = 8'd0;
  logic        in_line_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_position;
  logic        out_key_begin;
  logic        out_key_end;
  logic        out_name_begin;
  logic        out_name_end;
  logic        out_value_begin;
  logic        out_value_close;
  logic        out_value_extend;
  logic [3:0]  out_pair_index;
  logic [3:0]  out_pair_count;
  logic        out_ignored;

  directive_pair_tokenizer #(
    .MAX_PAIRS(PAIR_LIMIT),
    .MAX_LINE (LINE_LIMIT)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .in_line_start   (in_line_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_position    (out_position),
    .out_key_begin   (out_key_begin),
    .out_key_end     (out_key_end),
    .out_name_begin  (out_name_begin),
    .out_name_end    (out_name_end),
    .out_value_begin (out_value_begin),
    .out_value_close (out_value_close),
    .out_value_extend(out_value_extend),
    .out_pair_index  (out_pair_index),
    .out_pair_count  (out_pair_count),
    .out_ignored     (out_ignored)
  );

  always #5 clk = ~clk;

  // Characters waiting to be sent, and the marks we expect back, oldest first.
  line_char_t  pending_chars[$];
  dpt_result_t expected_marks[$];

  int in_offers   = 0;
  int in_accepts  = 0;
  int total_chars = 0;
  int mismatches  = 0;
  bit start_next  = 1'b0;

  // Long receiver hold-off, counted down in its own process.
  int hold_left    = 0;
  int next_hold_at = 400;

  // Tokenizer state as the bench sees it.
  logic [3:0]  scan_state   = ST_BEFORE_KEY;
  logic [3:0]  pairs_closed = '0;
  logic [11:0] next_pos     = '0;
  logic        line_ended   = 1'b0;

  function automatic bit is_space(input logic [7:0] ch);
    return ch == SPACE_CH || (ch >= TAB_CH && ch <= CR_CH);
  endfunction

  // Advance the tokenizer by one character and return the marks it produces.
  function automatic dpt_result_t tokenize_char(input logic [7:0] ch, input logic line_start);
    dpt_result_t r;
    logic        quote;
    logic        space;
    logic        may_extend;
    r = '0;
    if (line_start) begin
      scan_state   = ST_BEFORE_KEY;
      pairs_closed = '0;
      next_pos     = '0;
      line_ended   = 1'b0;
    end
    r.position = next_pos;
    if (next_pos < POS_LIMIT) next_pos = next_pos + 1'b1;

    if (line_ended || ch == NUL_CH || pairs_closed >= PAIR_LIMIT) begin
      if (ch == NUL_CH) line_ended = 1'b1;
      r.ignored = 1'b1;
    end else begin
      quote      = (ch == QUOTE_CH);
      space      = is_space(ch);
      may_extend = (pairs_closed != 0) && quote;
      // A late quote anywhere after a closed value pushes that value's end on,
      // except while a keyword, an '=' or a fresh value is being read.
      if (may_extend && !(scan_state inside {ST_BEFORE_KEY, ST_KEY, ST_EQ, ST_QUOTE,
                                              ST_VALUE})) begin
        r.value_extend = 1'b1;
        r.pair_index   = pairs_closed - 1'b1;
        scan_state     = ST_ENDQUOTE;
      end else begin
        case (scan_state)
          ST_BEFORE_KEY: begin
            if (!space) begin
              r.key_begin = 1'b1;
              scan_state  = ST_KEY;
            end
          end
          ST_KEY: begin
            if (space) begin
              r.key_end  = 1'b1;
              scan_state = ST_BEFORE_NAME;
            end
          end
          ST_BEFORE_NAME: begin
            if (!space) begin
              r.name_begin = 1'b1;
              r.pair_index = pairs_closed;
              scan_state   = ST_NAME;
            end
          end
          ST_NAME: begin
            if (space || ch == EQUAL_CH) begin
              r.name_end   = 1'b1;
              r.pair_index = pairs_closed;
              scan_state   = space ? ST_BEFORE_EQ : ST_EQ;
            end
          end
          ST_BEFORE_EQ: begin
            if (ch == EQUAL_CH) scan_state = ST_EQ;
            else if (!space) scan_state = ST_UNKNOWN;
          end
          ST_EQ: begin
            if (quote) scan_state = ST_QUOTE;
            else if (!space) scan_state = ST_UNKNOWN;
          end
          ST_QUOTE: begin
            r.value_begin = 1'b1;
            r.pair_index  = pairs_closed;
            if (quote) begin
              r.value_close = 1'b1;
              pairs_closed  = pairs_closed + 1'b1;
              scan_state    = ST_ENDQUOTE;
            end else begin
              scan_state = ST_VALUE;
            end
          end
          ST_VALUE: begin
            if (quote) begin
              r.value_close = 1'b1;
              r.pair_index  = pairs_closed;
              pairs_closed  = pairs_closed + 1'b1;
              scan_state    = ST_ENDQUOTE;
            end
          end
          ST_ENDQUOTE: begin
            scan_state = space ? ST_BEFORE_NAME : ST_UNKNOWN;
          end
          default: begin
            scan_state = ST_UNKNOWN;
          end
        endcase
      end
    end
    r.pair_count = pairs_closed;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Queue one character; the first one after start_next is raised opens a line.
  // noise_pct replaces the character by a random byte now and then.
  task automatic queue_char(input logic [7:0] ch, input int noise_pct = 0);
    line_char_t item;
    item.ch         = ($urandom_range(99) < noise_pct) ? 8'($urandom_range(255)) : ch;
    item.line_start = start_next;
    start_next      = 1'b0;
    pending_chars.push_back(item);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  function automatic logic [7:0] rand_space();
    int pick;
    pick = $urandom_range(5);
    return (pick == 5) ? SPACE_CH : 8'(TAB_CH + pick);
  endfunction

  // Anything that can sit inside a keyword or a name.
  function automatic logic [7:0] rand_word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (is_space(c) || c == QUOTE_CH || c == EQUAL_CH);
    return c;
  endfunction

  function automatic logic [7:0] rand_value_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == QUOTE_CH);
    return c;
  endfunction

  // One directive line: keyword then up to a dozen pairs, so that the pair
  // limit is hit now and then. Broken lines carry corrupted characters.
  task automatic queue_directive(input bit broken);
    int noise;
    noise      = broken ? 8 : 0;
    start_next = 1'b1;
    repeat ($urandom_range(2)) queue_char(rand_space(), noise);
    repeat ($urandom_range(1, 6)) queue_char(rand_word_char(), noise);
    repeat ($urandom_range(12)) begin
      repeat ($urandom_range(1, 3)) queue_char(rand_space(), noise);
      repeat ($urandom_range(1, 5)) queue_char(rand_word_char(), noise);
      repeat ($urandom_range(1)) queue_char(rand_space(), noise);
      queue_char(EQUAL_CH, noise);
      repeat ($urandom_range(1)) queue_char(rand_space(), noise);
      queue_char(QUOTE_CH, noise);
      repeat ($urandom_range(8)) queue_char(rand_value_char(), noise);
      queue_char(QUOTE_CH, noise);
      // Trailing quotes extend the value just closed.
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          repeat ($urandom_range(2)) queue_char(rand_value_char(), noise);
          queue_char(QUOTE_CH, noise);
        end
      end
    end
    // Terminate half the lines with a zero byte and some ignored tail.
    if ($urandom_range(1)) begin
      queue_char(NUL_CH);
      repeat ($urandom_range(4)) queue_char(8'($urandom_range(255)));
    end
  endtask

  task automatic queue_noise();
    line_char_t item;
    repeat ($urandom_range(10, 30)) begin
      item.ch         = 8'($urandom_range(255));
      item.line_start = ($urandom_range(7) == 0);
      pending_chars.push_back(item);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idling by phase: none, sender gaps, receiver stalls, both lightly, none.
  // ---------------------------------------------------------------------------
  function automatic int sender_gap_pct();
    case ((in_accepts / PHASE_LEN) % 5)
      1:       return 48;
      3:       return 12;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((in_accepts / PHASE_LEN) % 5)
      2:       return 48;
      3:       return 12;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: hold the current character until its transfer, then offer the
  // next one or idle.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_chars
    line_char_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_accepts != in_offers) begin
      // hold until the transfer
    end else if (pending_chars.size() == 0 ||
                 (hold_left == 0 && $urandom_range(99) < sender_gap_pct())) begin
      in_valid <= 1'b0;
    end else begin
      item = pending_chars.pop_front();
      in_ch         <= item.ch;
      in_line_start <= item.line_start;
      in_valid      <= 1'b1;
      in_offers++;
    end
  end

  // Receiver: random stalls, forced low during a hold-off.
  always @(negedge clk) begin
    if (!rst_n || hold_left != 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  // Hold the receiver off for a long stretch every so often so the block
  // backs up and drops in_ready while the sender keeps offering.
  always @(negedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (in_accepts >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_EVERY;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest expectation, then
  // predict the marks for any character transferred at this edge.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    dpt_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_marks.size() == 0) begin
          $error("result with nothing expected at position %0d", out_position);
          mismatches++;
        end else begin
          want = expected_marks.pop_front();
          check_field("position",     want.position,     out_position);
          check_field("key_begin",    want.key_begin,    out_key_begin);
          check_field("key_end",      want.key_end,      out_key_end);
          check_field("name_begin",   want.name_begin,   out_name_begin);
          check_field("name_end",     want.name_end,     out_name_end);
          check_field("value_begin",  want.value_begin,  out_value_begin);
          check_field("value_close",  want.value_close,  out_value_close);
          check_field("value_extend", want.value_extend, out_value_extend);
          check_field("pair_index",   want.pair_index,   out_pair_index);
          check_field("pair_count",   want.pair_count,   out_pair_count);
          check_field("ignored",      want.ignored,      out_ignored);
        end
      end
      if (in_valid && in_ready) begin
        expected_marks.push_back(tokenize_char(in_ch, in_line_start));
        in_accepts++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int directed_chars;
    int roll;

    // Directed line: a walk through the transitions, including empty values,
    // late quotes after a close, between pairs and in the unknown state, the
    // zero byte and the tail ignored after it.
    start_next = 1'b1;
    queue_char(8'd255);              // keyword begins on the top byte value
    queue_char(TAB_CH);              // keyword ends
    queue_text("a =");               // name, gap before '='
    queue_text("\"\"\"x\"");         // empty value, late quote, junk, late quote
    queue_char(CR_CH);               // back to between pairs
    queue_text("\"b\" c=\"v\"");     // late quotes between pairs and after stray text
    queue_char(NUL_CH);              // line ends
    queue_text("q");                 // ignored
    start_next = 1'b1;
    queue_text(" k d x");            // leading space, stray text after a name
    directed_chars = pending_chars.size();

    while (pending_chars.size() < directed_chars + RANDOM_CHARS) begin
      roll = $urandom_range(99);
      if (roll < 75) queue_directive(1'b0);
      else if (roll < 90) queue_directive(1'b1);
      else queue_noise();
    end

    // One long line to run the position counter well past the usual lengths.
    start_next = 1'b1;
    repeat (LONG_LINE) queue_char(rand_word_char(), 20);
    total_chars = pending_chars.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (in_accepts != total_chars || expected_marks.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && expected_marks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Give up if the stream stops moving.
  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
